// ===== src/rv32i_alu_execute_assert.svh =====
// Assertion macros shared by the ALU execute block.
`ifndef RV32I_ALU_EXECUTE_ASSERT_SVH
`define RV32I_ALU_EXECUTE_ASSERT_SVH

// Checked at every clock edge except while reset is held.
`define RVALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RVALU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/rvalu_pkg.sv =====
// Types and constants for the RV32I ALU execute block.
package rvalu_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [XLEN-1:0]   PC_STEP    = 32'd4;
    localparam logic [REG_AW-1:0] SHIFT_MASK = 5'h1F;
    localparam logic [REG_AW-1:0] REG_ZERO   = 5'd0;

    // Instruction classes.
    localparam logic [1:0] REQ_RR = 2'd0;
    localparam logic [1:0] REQ_RI = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_UNIMPL  = 2'd2;

    // funct3 operation codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct7 codes.
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic [REG_AW-1:0]  src1_index;
        logic [REG_AW-1:0]  src2_index;
        logic [REG_AW-1:0]  dest_index;
        logic signed [11:0] immediate;
        logic [XLEN-1:0]    instr_pc;
    } in_item_t;

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic [1:0]      status;
        logic            wrote_reg;
        logic [XLEN-1:0] result_value;
    } out_item_t;

    // Register file write-back request.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } wb_t;

endpackage

// ===== src/rvalu_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module rvalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== src/rvalu_core.sv =====
// Decode, ALU datapath and status logic for one instruction.
module rvalu_core (
    input  rvalu_pkg::in_item_t          item,
    input  logic [rvalu_pkg::XLEN-1:0]   op_a,
    input  logic [rvalu_pkg::XLEN-1:0]   op_rs2,
    output rvalu_pkg::out_item_t         res,
    output rvalu_pkg::wb_t               wb
);

    import rvalu_pkg::*;

    logic [XLEN-1:0]   imm32;
    logic [XLEN-1:0]   op_b;
    logic [REG_AW-1:0] shamt;
    logic              is_rr;
    logic              is_base;
    logic              is_alt;
    logic              illegal;
    logic              unimpl;
    logic              ok;
    logic [XLEN-1:0]   val;

    assign imm32   = XLEN'(item.immediate);
    assign is_rr   = (item.req_type == REQ_RR);
    assign op_b    = is_rr ? op_rs2 : imm32;
    assign shamt   = op_b[REG_AW-1:0] & SHIFT_MASK;
    assign is_base = (item.funct7 == F7_BASE);
    assign is_alt  = (item.funct7 == F7_ALT);
    assign unimpl  = (item.req_type != REQ_RR) && (item.req_type != REQ_RI);

    always_comb begin
        val     = '0;
        illegal = 1'b0;
        case (item.funct3)
            F3_ADD: begin
                val     = (is_rr && is_alt) ? op_a - op_b : op_a + op_b;
                illegal = is_rr && !is_base && !is_alt;
            end
            F3_SLL: begin
                val     = op_a << shamt;
                illegal = is_rr && !is_base;
            end
            F3_SLT: begin
                val     = XLEN'($signed(op_a) < $signed(op_b));
                illegal = is_rr && !is_base;
            end
            F3_SLTU: begin
                val     = XLEN'(op_a < op_b);
                illegal = is_rr && !is_base;
            end
            F3_XOR: begin
                val     = op_a ^ op_b;
                illegal = is_rr && !is_base;
            end
            F3_SR: begin
                // Both the register and the immediate form check funct7 here.
                val     = is_alt ? $unsigned($signed(op_a) >>> shamt) : op_a >> shamt;
                illegal = !is_base && !is_alt;
            end
            F3_OR: begin
                val     = op_a | op_b;
                illegal = is_rr && !is_base;
            end
            F3_AND: begin
                val     = op_a & op_b;
                illegal = is_rr && !is_base;
            end
            default: begin
                val     = '0;
                illegal = 1'b0;
            end
        endcase
    end

    assign ok = !unimpl && !illegal;

    always_comb begin
        res.next_pc      = ok ? item.instr_pc + PC_STEP : item.instr_pc;
        res.status       = unimpl ? ST_UNIMPL : (illegal ? ST_ILLEGAL : ST_OK);
        res.wrote_reg    = ok && (item.dest_index != REG_ZERO);
        res.result_value = ok ? val : '0;
        wb.en            = ok && (item.dest_index != REG_ZERO);
        wb.addr          = item.dest_index;
        wb.data          = val;
    end

endmodule

// ===== src/rv32i_alu_execute.sv =====
// RV32I ALU execute block: input register, ALU pass, result register.
// An accepted beat passes the input register, then the result register; a full
// result register not taken holds the input register. Throughput: one instruction
// per cycle barring such stalls; the ALU pass sits between the input register
// and the result register, and write-back is forwarded to the next read.
// Reset clears the pipeline valid flags and the per-register valid bits, so the
// whole register file reads as zero at once; register zero is never written.
module rv32i_alu_execute (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rvalu_pkg::in_item_t  s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rvalu_pkg::out_item_t m_payload
);

    import rvalu_pkg::*;

    `include "rv32i_alu_execute_assert.svh"

    in_item_t              in_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    out_item_t             out_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [REG_COUNT-1:0]  rf_valid_reg;
    logic                  rv1_reg;
    logic                  rv2_reg;
    logic                  fwd1_reg;
    logic                  fwd2_reg;
    logic [XLEN-1:0]       fwd_data_reg;
    logic [XLEN-1:0]       ram_q1;
    logic [XLEN-1:0]       ram_q2;
    logic [XLEN-1:0]       op_a;
    logic [XLEN-1:0]       op_rs2;
    out_item_t             core_res;
    wb_t                   core_wb;
    logic                  accept;
    logic                  advance;
    logic                  wb_en;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign wb_en   = advance && core_wb.en;

    rvalu_ram #(
        .WIDTH(XLEN),
        .DEPTH(REG_COUNT)
    ) u_regfile (
        .aclk      (aclk),
        .wr_en     (wb_en),
        .wr_addr   (core_wb.addr),
        .wr_data   (core_wb.data),
        .rd_en     (accept),
        .rd_addr_a (s_payload.src1_index),
        .rd_addr_b (s_payload.src2_index),
        .rd_data_a (ram_q1),
        .rd_data_b (ram_q2)
    );

    // A write landing in the same cycle as the read wins over the stale RAM data.
    assign op_a   = fwd1_reg ? fwd_data_reg : (rv1_reg ? ram_q1 : '0);
    assign op_rs2 = fwd2_reg ? fwd_data_reg : (rv2_reg ? ram_q2 : '0);

    rvalu_core u_core (
        .item   (in_reg),
        .op_a   (op_a),
        .op_rs2 (op_rs2),
        .res    (core_res),
        .wb     (core_wb)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (wb_en) begin
                rf_valid_reg[core_wb.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg       <= s_payload;
            rv1_reg      <= rf_valid_reg[s_payload.src1_index];
            rv2_reg      <= rf_valid_reg[s_payload.src2_index];
            fwd1_reg     <= wb_en && (core_wb.addr == s_payload.src1_index);
            fwd2_reg     <= wb_en && (core_wb.addr == s_payload.src2_index);
            fwd_data_reg <= core_wb.data;
        end
        if (advance) begin
            out_reg <= core_res;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    `RVALU_ASSERT(a_err_no_write, m_valid && (m_payload.status != ST_OK) |-> !m_payload.wrote_reg && (m_payload.result_value == '0), "Error result carries a write or a value")
    `RVALU_ASSERT(a_no_zero_write, wb_en |-> (core_wb.addr != REG_ZERO), "Write-back aimed at register zero")
    `RVALU_ASSERT(a_zero_invalid, !rf_valid_reg[0], "Register zero marked as written")
    `RVALU_ASSERT(a_advance_out, advance |=> m_valid, "Result register did not load after advance")

endmodule

// ===== verif/rv32i_alu_execute_checker.sv =====
// Checker for the RV32I ALU execute block: predicts every result beat and compares it.
`timescale 1ns / 100ps
module rv32i_alu_execute_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  rvalu_pkg::in_item_t  s_payload,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  rvalu_pkg::out_item_t m_payload,
    output int                   error_count,
    output int                   pending_results,
    output int                   results_checked,
    output int                   illegal_seen,
    output int                   unimpl_seen
);

    import rvalu_pkg::*;

    logic [XLEN-1:0] arch_regs [REG_COUNT];
    out_item_t       expected_results [$];
    int              n_errors = 0;
    int              n_checked = 0;
    int              n_illegal = 0;
    int              n_unimpl = 0;

    // Executes one instruction against the shadow register file.
    function automatic out_item_t execute_alu(input in_item_t instr);
        logic [XLEN-1:0]   op_a;
        logic [XLEN-1:0]   op_b;
        logic [XLEN-1:0]   value;
        logic [REG_AW-1:0] shamt;
        logic [1:0]        st;
        logic              is_base;
        logic              is_alt;
        out_item_t         res;
        is_base = (instr.funct7 == F7_BASE);
        is_alt  = (instr.funct7 == F7_ALT);
        op_a    = (instr.src1_index == REG_ZERO) ? '0 : arch_regs[instr.src1_index];
        op_b    = '0;
        st      = ST_OK;
        case (instr.req_type)
            REQ_RR: begin
                op_b = (instr.src2_index == REG_ZERO) ? '0 : arch_regs[instr.src2_index];
                if (!is_base && !(is_alt && (instr.funct3 == F3_ADD || instr.funct3 == F3_SR)))
                    st = ST_ILLEGAL;
            end
            REQ_RI: begin
                op_b = {{(XLEN-12){instr.immediate[11]}}, instr.immediate};
                // Only the shift-right immediate looks at funct7.
                if (instr.funct3 == F3_SR && !is_base && !is_alt)
                    st = ST_ILLEGAL;
            end
            default: st = ST_UNIMPL;
        endcase
        shamt = op_b[REG_AW-1:0] & SHIFT_MASK;
        case (instr.funct3)
            F3_ADD:  value = (instr.req_type == REQ_RR && is_alt) ? op_a - op_b : op_a + op_b;
            F3_SLL:  value = op_a << shamt;
            F3_SLT:  value = ($signed(op_a) < $signed(op_b)) ? 32'd1 : 32'd0;
            F3_SLTU: value = (op_a < op_b) ? 32'd1 : 32'd0;
            F3_XOR:  value = op_a ^ op_b;
            F3_SR:   value = is_alt ? $unsigned($signed(op_a) >>> shamt) : op_a >> shamt;
            F3_OR:   value = op_a | op_b;
            default: value = op_a & op_b;
        endcase
        if (st != ST_OK) begin
            res.next_pc      = instr.instr_pc;
            res.status       = st;
            res.wrote_reg    = 1'b0;
            res.result_value = '0;
        end else begin
            if (instr.dest_index != REG_ZERO)
                arch_regs[instr.dest_index] = value;
            res.next_pc      = instr.instr_pc + PC_STEP;
            res.status       = ST_OK;
            res.wrote_reg    = (instr.dest_index != REG_ZERO);
            res.result_value = value;
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", field, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            expected_results.delete();
            foreach (arch_regs[i]) arch_regs[i] = '0;
        end else begin
            if (s_valid && s_ready) begin
                want = execute_alu(s_payload);
                if (want.status == ST_ILLEGAL) n_illegal++;
                if (want.status == ST_UNIMPL) n_unimpl++;
                expected_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no instruction outstanding: %p", m_payload);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("next_pc", want.next_pc, m_payload.next_pc);
                    check_field("status", XLEN'(want.status), XLEN'(m_payload.status));
                    check_field("wrote_reg", XLEN'(want.wrote_reg),
                                XLEN'(m_payload.wrote_reg));
                    check_field("result_value", want.result_value, m_payload.result_value);
                    n_checked++;
                end
            end
        end
        error_count     <= n_errors;
        pending_results <= expected_results.size();
        results_checked <= n_checked;
        illegal_seen    <= n_illegal;
        unimpl_seen     <= n_unimpl;
    end

endmodule

// ===== verif/rv32i_alu_execute_tb.sv =====
// Testbench top for the RV32I ALU execute block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module rv32i_alu_execute_tb;
    import rvalu_pkg::*;

    localparam logic [1:0] REQ_OTHER    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;
    localparam int         BEATS_PER_PHASE = 156;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         WATCHDOG_LIMIT  = 2000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    int error_count;
    int pending_results;
    int results_checked;
    int illegal_seen;
    int unimpl_seen;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int beats_sent = 0;
    int idle_cycles = 0;

    int src_idle_mix [4]  = '{0, 46, 0, 14};
    int sink_stall_mix [4] = '{0, 0, 46, 14};

    always #2 aclk = ~aclk;

    rv32i_alu_execute dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    rv32i_alu_execute_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .error_count     (error_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .illegal_seen    (illegal_seen),
        .unimpl_seen     (unimpl_seen)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rv32i_alu_execute regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic in_item_t make_instr(input logic [1:0] rtype, input logic [2:0] f3,
                                            input logic [6:0] f7, input int rs1, input int rs2,
                                            input int rd, input int imm, input logic [31:0] pc);
        in_item_t instr;
        instr.req_type   = rtype;
        instr.funct3     = f3;
        instr.funct7     = f7;
        instr.src1_index = rs1[REG_AW-1:0];
        instr.src2_index = rs2[REG_AW-1:0];
        instr.dest_index = rd[REG_AW-1:0];
        instr.immediate  = imm[11:0];
        instr.instr_pc   = pc;
        return instr;
    endfunction

    function automatic in_item_t random_instr();
        int          pick;
        logic [1:0]  rtype;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] pc;
        pick = $urandom_range(99);
        if (pick < 45)
            rtype = REQ_RR;
        else if (pick < 92)
            rtype = REQ_RI;
        else
            rtype = $urandom_range(1) ? REQ_OTHER : REQ_RESERVED;
        f3 = 3'($urandom_range(7));
        // Mostly legal encodings so the register file keeps evolving.
        pick = $urandom_range(99);
        if (pick < 65)
            f7 = F7_BASE;
        else if (pick < 88)
            f7 = (f3 == F3_ADD || f3 == F3_SR) ? F7_ALT : F7_BASE;
        else
            f7 = 7'($urandom_range(127));
        pc = $urandom();
        if ($urandom_range(15) == 0)
            pc[31:2] = '1;
        return make_instr(rtype, f3, f7, $urandom_range(31), $urandom_range(31),
                          $urandom_range(31), $urandom_range(4095), pc);
    endfunction

    // Leaves valid high after acceptance so back-to-back beats need no gap.
    task automatic send_beat(input in_item_t instr);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= instr;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed();
        in_item_t seq [$];
        // Seed x1..x3 with the immediate extremes and -1, with a pc that wraps.
        seq.push_back(make_instr(REQ_RI, F3_ADD, F7_BASE, 0, 0, 1, -2048, 32'h0000_0000));
        seq.push_back(make_instr(REQ_RI, F3_ADD, F7_BASE, 0, 0, 2, 2047, 32'hFFFF_FFFC));
        seq.push_back(make_instr(REQ_RI, F3_ADD, F7_BASE, 0, 0, 3, -1, 32'hFFFF_FFFF));
        seq.push_back(make_instr(REQ_RR, F3_ADD, F7_BASE, 1, 2, 4, 0, 32'h0000_0100));
        seq.push_back(make_instr(REQ_RR, F3_ADD, F7_ALT, 1, 2, 5, 0, 32'h0000_0104));
        seq.push_back(make_instr(REQ_RR, F3_SLL, F7_BASE, 3, 2, 6, 0, 32'h0000_0108));
        seq.push_back(make_instr(REQ_RR, F3_SLT, F7_BASE, 1, 2, 7, 0, 32'h0000_010C));
        seq.push_back(make_instr(REQ_RR, F3_SLTU, F7_BASE, 1, 2, 8, 0, 32'h0000_0110));
        seq.push_back(make_instr(REQ_RR, F3_XOR, F7_BASE, 1, 3, 9, 0, 32'h0000_0114));
        seq.push_back(make_instr(REQ_RR, F3_SR, F7_BASE, 3, 2, 10, 0, 32'h0000_0118));
        seq.push_back(make_instr(REQ_RR, F3_SR, F7_ALT, 1, 2, 11, 0, 32'h0000_011C));
        seq.push_back(make_instr(REQ_RR, F3_OR, F7_BASE, 1, 2, 12, 0, 32'h0000_0120));
        seq.push_back(make_instr(REQ_RR, F3_AND, F7_BASE, 1, 3, 13, 0, 32'h0000_0124));
        // Destination x0: succeeds with a value but writes nothing.
        seq.push_back(make_instr(REQ_RR, F3_ADD, F7_BASE, 1, 3, 0, 0, 32'h0000_0128));
        seq.push_back(make_instr(REQ_RR, F3_ADD, F7_BASE, 0, 0, 14, 0, 32'h0000_012C));
        // Bad funct7 on register-register forms.
        seq.push_back(make_instr(REQ_RR, F3_XOR, F7_ALT, 1, 2, 15, 0, 32'h8000_0000));
        seq.push_back(make_instr(REQ_RR, F3_ADD, 7'h7F, 1, 2, 15, 0, 32'h7FFF_FFFC));
        // Shift-right immediate: both legal forms, then a bad funct7.
        seq.push_back(make_instr(REQ_RI, F3_SR, F7_ALT, 1, 0, 16, 12'h7E4, 32'h0000_0200));
        seq.push_back(make_instr(REQ_RI, F3_SR, F7_BASE, 3, 0, 17, 12'h01F, 32'h0000_0204));
        seq.push_back(make_instr(REQ_RI, F3_SR, 7'h7F, 1, 0, 17, 4, 32'h0000_0208));
        // Immediate forms other than shift right ignore funct7.
        seq.push_back(make_instr(REQ_RI, F3_SLT, 7'h7F, 1, 0, 18, -1, 32'h0000_020C));
        seq.push_back(make_instr(REQ_RI, F3_SLTU, 7'h55, 2, 0, 19, -1, 32'h0000_0210));
        seq.push_back(make_instr(REQ_RI, F3_SLL, 7'h2A, 3, 0, 20, 12'hFE3, 32'h0000_0214));
        seq.push_back(make_instr(REQ_OTHER, F3_ADD, F7_BASE, 1, 2, 21, 5, 32'h0000_0218));
        seq.push_back(make_instr(REQ_RESERVED, F3_AND, 7'h7F, 31, 31, 31, -2048,
                                 32'hFFFF_FFFF));
        foreach (seq[i]) send_beat(seq[i]);
    endtask

    initial begin
        int directed_count;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sink_stall_pct = 46;
        run_directed();
        directed_count = beats_sent;
        wait_for_results();
        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct   = src_idle_mix[phase];
            sink_stall_pct = sink_stall_mix[phase];
            repeat (BEATS_PER_PHASE) begin
                send_beat(random_instr());
                // Now and then hold off until the pipeline has fully drained.
                if ($urandom_range(59) == 0)
                    wait_for_results();
            end
            wait_for_results();
        end
        $display("Covered %0d instructions (%0d directed) and checked %0d result beats",
                 beats_sent, directed_count, results_checked);
        $display("over four idle/stall mixes; %0d illegal and %0d unimplemented encodings.",
                 illegal_seen, unimpl_seen);
        if (error_count == 0) begin
            $display("rv32i_alu_execute regression: pass");
        end else begin
            $display("rv32i_alu_execute regression: fail");
        end
        $finish;
    end

endmodule
